// File: rtl/mamt_pkg.sv
// ----------------------------------------------------------------------------
// mamt_pkg
// Shared types and codes for the matrix add / multiply / transpose core.
// ----------------------------------------------------------------------------
package mamt_pkg;

   localparam int MAX_DIM_DEFAULT   = 16;
   localparam int ELEM_BITS_DEFAULT = 16;

   localparam int DIM_BITS    = 5;
   localparam int IDX_BITS    = 4;
   localparam int INPUT_BITS  = 16;
   localparam int RESULT_BITS = 40;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   localparam logic [1:0] MODE_ADD       = 2'd0;
   localparam logic [1:0] MODE_MUL       = 2'd1;
   localparam logic [1:0] MODE_TRANSPOSE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DIMS  = 2'd1;
   localparam logic [1:0] STATUS_INDEX = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS_A = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLS_A = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS_B = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLS_B = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic       start;
      logic       issue;
      logic       last;
      logic [1:0] kind;
   } mac_ctrl_type;

endpackage

// File: rtl/mamt_ram.sv
// ----------------------------------------------------------------------------
// mamt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mamt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/mamt_mac.sv
// ----------------------------------------------------------------------------
// mamt_mac
// Term and accumulate pipeline behind the two store read ports: forms the
// product, sum or copy of the read data, then accumulates to the result.
// ----------------------------------------------------------------------------
module mamt_mac #(
   parameter int ELEM_BITS = mamt_pkg::ELEM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mamt_pkg::mac_ctrl_type              ctrl,
   input  logic [ELEM_BITS-1:0]                a_rdata,
   input  logic [ELEM_BITS-1:0]                b_rdata,
   output logic                                done,
   output logic [mamt_pkg::RESULT_BITS-1:0]    acc
);

   localparam int TW = 2 * ELEM_BITS;

   logic                              s1_vld_ff, s1_vld_in;
   logic                              s1_last_ff, s1_last_in;
   logic                              s2_vld_ff, s2_vld_in;
   logic                              s2_last_ff, s2_last_in;
   logic                              done_ff, done_in;
   logic [TW-1:0]                     term_ff, term_in;
   logic [mamt_pkg::RESULT_BITS-1:0]  acc_ff, acc_in;

   always_comb begin
      s1_vld_in  = ctrl.issue;
      s1_last_in = ctrl.issue && ctrl.last;
      s2_vld_in  = s1_vld_ff;
      s2_last_in = s1_last_ff;

      case (ctrl.kind)
         mamt_pkg::MODE_MUL: term_in = TW'(a_rdata) * TW'(b_rdata);
         mamt_pkg::MODE_ADD: term_in = TW'(a_rdata) + TW'(b_rdata);
         default:            term_in = TW'(a_rdata);
      endcase

      if (ctrl.start) begin
         acc_in  = '0;
         done_in = 1'b0;
      end else begin
         acc_in  = s2_vld_ff ? acc_ff + mamt_pkg::RESULT_BITS'(term_ff) : acc_ff;
         done_in = done_ff || (s2_vld_ff && s2_last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s1_last_ff <= s1_last_in;
         s2_vld_ff  <= s2_vld_in;
         s2_last_ff <= s2_last_in;
         done_ff    <= done_in;
      end
      term_ff <= term_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// File: rtl/matrix_add_multiply_transpose_core.sv
// ----------------------------------------------------------------------------
// matrix_add_multiply_transpose_core
// Holds matrices A and B in two RAMs and computes one result element per read
// transaction: element-wise add, matrix multiply, or transpose of A.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: operation; tdata: row, col, element
//   rsp      out  rsp_tvalid/tready    tuser: status; tdata: result_value
//   csr      in   csr_we               csr_index, csr_wdata
//
// A write completes on acceptance; a read with a status error goes straight to
// the response. Other reads pass ISSUE and DRAIN; a multiply read issues one
// multiply-accumulate per cycle, set by the single read port of each RAM.
// Synchronous reset clears control and configuration; RAM contents are kept.
// A waiting response does not block writes; a read finishing behind a stalled
// response holds until the output register frees.
// ----------------------------------------------------------------------------
module matrix_add_multiply_transpose_core #(
   parameter int MAX_DIM   = mamt_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_BITS = mamt_pkg::ELEM_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,  // row, col, element
   input  logic [1:0]                            req_tuser,  // operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mamt_pkg::RESULT_BITS-1:0]      rsp_tdata,  // result_value
   output logic [1:0]                            rsp_tuser,  // status
   input  logic                                  csr_we,
   input  logic [mamt_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [mamt_pkg::DIM_BITS-1:0]         csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DB    = mamt_pkg::DIM_BITS;
   localparam int IB    = mamt_pkg::IDX_BITS;
   localparam int RB    = mamt_pkg::RESULT_BITS;

   function automatic logic [AW-1:0] cell_addr(input logic [DB-1:0] r,
                                                input logic [DB-1:0] c);
      int sum;
      sum = int'(r) * MAX_DIM + int'(c);
      return AW'(sum);
   endfunction

   function automatic logic dim_ok(input logic [DB-1:0] d);
      return (d != '0) && (int'(d) <= MAX_DIM);
   endfunction

   logic [1:0]               mode_ff;
   logic [DB-1:0]            rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   mamt_pkg::state_type      state_ff, state_in;
   logic [DB-1:0]            k_ff, k_in;
   logic [IB-1:0]            row_ff, row_in, col_ff, col_in;
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0]            rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic [1:0]               req_op;
   logic [IB-1:0]            req_row, req_col;
   logic [mamt_pkg::INPUT_BITS-1:0] req_elem;
   logic [DB-1:0]            row_x, col_x;
   logic                     wr_ok_a, wr_ok_b, in_max;
   logic [1:0]               rd_status;
   logic                     out_free, issue_last;

   logic                     a_we, b_we;
   logic [AW-1:0]            w_addr, a_raddr, b_raddr;
   logic [ELEM_BITS-1:0]     w_data, a_rdata, b_rdata;
   mamt_pkg::mac_ctrl_type   mac_ctrl;
   logic                     mac_done;
   logic [RB-1:0]            mac_acc;

   assign req_op   = req_tuser;
   assign req_row  = req_tdata[3:0];
   assign req_col  = req_tdata[7:4];
   assign req_elem = req_tdata[23:8];
   assign row_x    = DB'(req_row);
   assign col_x    = DB'(req_col);
   assign w_addr   = cell_addr(row_x, col_x);
   assign w_data   = ELEM_BITS'(req_elem);

   always_comb begin
      in_max  = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
      wr_ok_a = in_max && (row_x < rows_a_ff) && (col_x < cols_a_ff);
      wr_ok_b = in_max && (row_x < rows_b_ff) && (col_x < cols_b_ff);

      case (mode_ff)
         mamt_pkg::MODE_ADD: begin
            if (!dim_ok(rows_a_ff) || !dim_ok(cols_a_ff) ||
                rows_a_ff != rows_b_ff || cols_a_ff != cols_b_ff) begin
               rd_status = mamt_pkg::STATUS_DIMS;
            end else if (row_x >= rows_a_ff || col_x >= cols_a_ff) begin
               rd_status = mamt_pkg::STATUS_INDEX;
            end else begin
               rd_status = mamt_pkg::STATUS_OK;
            end
         end
         mamt_pkg::MODE_MUL: begin
            if (!dim_ok(rows_a_ff) || !dim_ok(cols_a_ff) || !dim_ok(cols_b_ff) ||
                cols_a_ff != rows_b_ff) begin
               rd_status = mamt_pkg::STATUS_DIMS;
            end else if (row_x >= rows_a_ff || col_x >= cols_b_ff) begin
               rd_status = mamt_pkg::STATUS_INDEX;
            end else begin
               rd_status = mamt_pkg::STATUS_OK;
            end
         end
         mamt_pkg::MODE_TRANSPOSE: begin
            if (!dim_ok(rows_a_ff) || !dim_ok(cols_a_ff)) begin
               rd_status = mamt_pkg::STATUS_DIMS;
            end else if (row_x >= cols_a_ff || col_x >= rows_a_ff) begin
               rd_status = mamt_pkg::STATUS_INDEX;
            end else begin
               rd_status = mamt_pkg::STATUS_OK;
            end
         end
         default: rd_status = mamt_pkg::STATUS_DIMS;
      endcase
   end

   always_comb begin
      case (mode_ff)
         mamt_pkg::MODE_MUL: begin
            a_raddr = cell_addr(DB'(row_ff), k_ff);
            b_raddr = cell_addr(k_ff, DB'(col_ff));
         end
         mamt_pkg::MODE_TRANSPOSE: begin
            a_raddr = cell_addr(DB'(col_ff), DB'(row_ff));
            b_raddr = cell_addr(DB'(row_ff), DB'(col_ff));
         end
         default: begin
            a_raddr = cell_addr(DB'(row_ff), DB'(col_ff));
            b_raddr = cell_addr(DB'(row_ff), DB'(col_ff));
         end
      endcase
   end

   assign issue_last = (mode_ff != mamt_pkg::MODE_MUL) || (k_ff == cols_a_ff - DB'(1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      req_tready     = 1'b0;
      a_we           = 1'b0;
      b_we           = 1'b0;
      mac_ctrl.start = 1'b0;
      mac_ctrl.issue = 1'b0;
      mac_ctrl.last  = issue_last;
      mac_ctrl.kind  = mode_ff;

      case (state_ff)
         mamt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_op)
                  mamt_pkg::OP_WRITE_A: a_we = wr_ok_a;
                  mamt_pkg::OP_WRITE_B: b_we = wr_ok_b;
                  mamt_pkg::OP_READ: begin
                     row_in    = req_row;
                     col_in    = req_col;
                     status_in = rd_status;
                     k_in      = '0;
                     if (rd_status == mamt_pkg::STATUS_OK) begin
                        mac_ctrl.start = 1'b1;
                        state_in       = mamt_pkg::S_ISSUE;
                     end else begin
                        state_in = mamt_pkg::S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         mamt_pkg::S_ISSUE: begin
            mac_ctrl.issue = 1'b1;
            k_in           = k_ff + DB'(1);
            if (issue_last) begin
               state_in = mamt_pkg::S_DRAIN;
            end
         end
         mamt_pkg::S_DRAIN: begin
            if (mac_done) begin
               state_in = mamt_pkg::S_EMIT;
            end
         end
         mamt_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (status_ff == mamt_pkg::STATUS_OK) ? mac_acc : '0;
               rsp_status_in = status_ff;
               state_in      = mamt_pkg::S_IDLE;
            end
         end
         default: state_in = mamt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mamt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= mamt_pkg::MODE_ADD;
         rows_a_ff    <= DB'(1);
         cols_a_ff    <= DB'(1);
         rows_b_ff    <= DB'(1);
         cols_b_ff    <= DB'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               mamt_pkg::CSR_MODE:   mode_ff   <= csr_wdata[1:0];
               mamt_pkg::CSR_ROWS_A: rows_a_ff <= csr_wdata;
               mamt_pkg::CSR_COLS_A: cols_a_ff <= csr_wdata;
               mamt_pkg::CSR_ROWS_B: rows_b_ff <= csr_wdata;
               mamt_pkg::CSR_COLS_B: cols_b_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      k_ff          <= k_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   mamt_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock (clock),
      .we    (a_we),
      .waddr (w_addr),
      .wdata (w_data),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mamt_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock (clock),
      .we    (b_we),
      .waddr (w_addr),
      .wdata (w_data),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   mamt_mac #(
      .ELEM_BITS (ELEM_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_rdata (a_rdata),
      .b_rdata (b_rdata),
      .done    (mac_done),
      .acc     (mac_acc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/mamt_checker.sv
// ----------------------------------------------------------------------------
// mamt_checker
// Port-level checks for the matrix add / multiply / transpose core.
// ----------------------------------------------------------------------------
module mamt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [1:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mamt_pkg::RESULT_BITS-1:0]  rsp_tdata,
   input logic [1:0]                        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != mamt_pkg::STATUS_OK |-> rsp_tdata == '0)
      else $error("error response carries nonzero value");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != mamt_pkg::OP_READ && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("write transaction produced a response");

endmodule

bind matrix_add_multiply_transpose_core mamt_checker u_mamt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: bench/tb_matrix_add_multiply_transpose_core.sv
// ----------------------------------------------------------------------------
// tb_matrix_add_multiply_transpose_core
// Self-checking bench for the matrix add / multiply / transpose core. A shadow
// copy of both matrices and the CSR set predicts every read response; each
// response is checked field by field against the oldest prediction. Directed
// tests cover reset state, shape and dimension errors, index errors and value
// extremes, then randomized shape sessions run under varying idle patterns.
// ----------------------------------------------------------------------------
module tb_matrix_add_multiply_transpose_core;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int MAX_DIM      = mamt_pkg::MAX_DIM_DEFAULT;
   localparam int RB           = mamt_pkg::RESULT_BITS;
   localparam int CIB          = mamt_pkg::CSR_IDX_BITS;
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [RB-1:0] value;
      logic [1:0]    status;
   } element_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [23:0]             req_tdata = '0;   // row, col, element
   logic [1:0]              req_tuser = '0;   // operation
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RB-1:0]           rsp_tdata;        // result_value
   logic [1:0]              rsp_tuser;        // status
   logic                    csr_we = 1'b0;
   logic [CIB-1:0]          csr_index = '0;
   logic [mamt_pkg::DIM_BITS-1:0] csr_wdata = '0;

   // shadow state of the core
   logic [15:0]   mem_a [MAX_DIM*MAX_DIM];
   logic [15:0]   mem_b [MAX_DIM*MAX_DIM];
   bit            loaded_a [MAX_DIM*MAX_DIM];
   bit            loaded_b [MAX_DIM*MAX_DIM];
   logic [1:0]    cfg_mode = mamt_pkg::MODE_ADD;
   logic [4:0]    cfg_rows_a = 5'd1;
   logic [4:0]    cfg_cols_a = 5'd1;
   logic [4:0]    cfg_rows_b = 5'd1;
   logic [4:0]    cfg_cols_b = 5'd1;

   element_result_type expected_elements [$];
   int            mismatches = 0;
   int            sent_items = 0;
   int            req_idle_pct = 7;
   int            rsp_idle_pct = 57;
   int            hold_requests = 0;
   int            holds_taken = 0;
   int            hold_left = 0;
   int            stalled_cycles = 0;

   matrix_add_multiply_transpose_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit dim_in_range(input logic [4:0] d);
      return d >= 5'd1 && d <= 5'(MAX_DIM);
   endfunction

   function automatic logic [1:0] compute_element(input logic [3:0] r, input logic [3:0] c,
                                                  output logic [RB-1:0] value);
      logic [RB-1:0] acc;
      value = '0;
      acc = '0;
      case (cfg_mode)
         mamt_pkg::MODE_ADD: begin
            if (!dim_in_range(cfg_rows_a) || !dim_in_range(cfg_cols_a) ||
                cfg_rows_a != cfg_rows_b || cfg_cols_a != cfg_cols_b)
               return mamt_pkg::STATUS_DIMS;
            if (r >= cfg_rows_a || c >= cfg_cols_a)
               return mamt_pkg::STATUS_INDEX;
            value = RB'(mem_a[{r, c}]) + RB'(mem_b[{r, c}]);
            return mamt_pkg::STATUS_OK;
         end
         mamt_pkg::MODE_MUL: begin
            if (!dim_in_range(cfg_rows_a) || !dim_in_range(cfg_cols_a) ||
                !dim_in_range(cfg_cols_b) || cfg_cols_a != cfg_rows_b)
               return mamt_pkg::STATUS_DIMS;
            if (r >= cfg_rows_a || c >= cfg_cols_b)
               return mamt_pkg::STATUS_INDEX;
            for (int k = 0; k < cfg_cols_a; k++)
               acc += RB'(mem_a[{r, 4'(k)}]) * RB'(mem_b[{4'(k), c}]);
            value = acc;
            return mamt_pkg::STATUS_OK;
         end
         mamt_pkg::MODE_TRANSPOSE: begin
            if (!dim_in_range(cfg_rows_a) || !dim_in_range(cfg_cols_a))
               return mamt_pkg::STATUS_DIMS;
            if (r >= cfg_cols_a || c >= cfg_rows_a)
               return mamt_pkg::STATUS_INDEX;
            value = RB'(mem_a[{c, r}]);
            return mamt_pkg::STATUS_OK;
         end
         default: return mamt_pkg::STATUS_DIMS;
      endcase
   endfunction

   function automatic logic [15:0] random_element();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [4:0] pick_dim();
      case ($urandom_range(9))
         0, 1: return 5'd1;
         2: return 5'(MAX_DIM);
         default: return 5'($urandom_range(2, 6));
      endcase
   endfunction

   function automatic logic [3:0] pick_index(input int limit);
      if (limit >= 1 && limit <= MAX_DIM && $urandom_range(9) != 0)
         return 4'($urandom_range(limit - 1));
      return 4'($urandom_range(15));
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // drive one request transaction and fold it into the shadow state on acceptance
   task automatic send_transaction(input logic [1:0] op, input logic [3:0] row,
                                   input logic [3:0] col, input logic [15:0] elem);
      element_result_type expected;
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {elem, col, row};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sent_items++;
      case (op)
         mamt_pkg::OP_WRITE_A: begin
            if (row < cfg_rows_a && col < cfg_cols_a) begin
               mem_a[{row, col}] = elem;
               loaded_a[{row, col}] = 1'b1;
            end
         end
         mamt_pkg::OP_WRITE_B: begin
            if (row < cfg_rows_b && col < cfg_cols_b) begin
               mem_b[{row, col}] = elem;
               loaded_b[{row, col}] = 1'b1;
            end
         end
         mamt_pkg::OP_READ: begin
            expected.status = compute_element(row, col, expected.value);
            expected_elements.push_back(expected);
         end
         default: ;
      endcase
   endtask

   task automatic load_if_empty(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c);
      if (op == mamt_pkg::OP_WRITE_A ? !loaded_a[{r, c}] : !loaded_b[{r, c}])
         send_transaction(op, r, c, random_element());
   endtask

   // load every operand the read depends on, then issue the read
   task automatic read_element(input logic [3:0] r, input logic [3:0] c);
      logic [RB-1:0] value;
      if (compute_element(r, c, value) == mamt_pkg::STATUS_OK) begin
         case (cfg_mode)
            mamt_pkg::MODE_ADD: begin
               load_if_empty(mamt_pkg::OP_WRITE_A, r, c);
               load_if_empty(mamt_pkg::OP_WRITE_B, r, c);
            end
            mamt_pkg::MODE_MUL: begin
               for (int k = 0; k < cfg_cols_a; k++) begin
                  load_if_empty(mamt_pkg::OP_WRITE_A, r, 4'(k));
                  load_if_empty(mamt_pkg::OP_WRITE_B, 4'(k), c);
               end
            end
            default: load_if_empty(mamt_pkg::OP_WRITE_A, c, r);
         endcase
      end
      send_transaction(mamt_pkg::OP_READ, r, c, 16'($urandom()));
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CIB-1:0] idx, input logic [4:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         mamt_pkg::CSR_MODE:   cfg_mode   = data[1:0];
         mamt_pkg::CSR_ROWS_A: cfg_rows_a = data;
         mamt_pkg::CSR_COLS_A: cfg_cols_a = data;
         mamt_pkg::CSR_ROWS_B: cfg_rows_b = data;
         mamt_pkg::CSR_COLS_B: cfg_cols_b = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] m, input logic [4:0] ra, input logic [4:0] ca,
                            input logic [4:0] rb, input logic [4:0] cb);
      quiesce();
      write_csr(mamt_pkg::CSR_MODE, {3'($urandom_range(7)), m});
      write_csr(mamt_pkg::CSR_ROWS_A, ra);
      write_csr(mamt_pkg::CSR_COLS_A, ca);
      write_csr(mamt_pkg::CSR_ROWS_B, rb);
      write_csr(mamt_pkg::CSR_COLS_B, cb);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_transaction(mamt_pkg::OP_WRITE_A, 4'd0, 4'd0, 16'hffff);
      send_transaction(mamt_pkg::OP_WRITE_B, 4'd0, 4'd0, 16'hffff);
      read_element(4'd0, 4'd0);
      read_element(4'd0, 4'd1);
      send_transaction(mamt_pkg::OP_WRITE_A, 4'd1, 4'd0, 16'h1234);
      send_transaction(OP_UNUSED, 4'd0, 4'd0, 16'h0001);
      read_element(4'd0, 4'd0);
   endtask

   task automatic test_add_extremes();
      configure(mamt_pkg::MODE_ADD, 5'd16, 5'd16, 5'd16, 5'd16);
      send_transaction(mamt_pkg::OP_WRITE_A, 4'd15, 4'd15, 16'h0000);
      send_transaction(mamt_pkg::OP_WRITE_B, 4'd15, 4'd15, 16'hffff);
      read_element(4'd15, 4'd15);
   endtask

   task automatic test_multiply_shapes();
      configure(mamt_pkg::MODE_MUL, 5'd2, 5'd3, 5'd3, 5'd2);
      read_element(4'd1, 4'd1);
      read_element(4'd2, 4'd0);
      configure(mamt_pkg::MODE_MUL, 5'd2, 5'd3, 5'd2, 5'd2);
      read_element(4'd0, 4'd0);
   endtask

   task automatic test_transpose();
      configure(mamt_pkg::MODE_TRANSPOSE, 5'd3, 5'd16, 5'd0, 5'd0);
      read_element(4'd15, 4'd2);
      read_element(4'd2, 4'd15);
   endtask

   task automatic test_dimension_errors();
      configure(mamt_pkg::MODE_ADD, 5'd0, 5'd0, 5'd0, 5'd0);
      read_element(4'd0, 4'd0);
      configure(mamt_pkg::MODE_TRANSPOSE, 5'd17, 5'd4, 5'd4, 5'd4);
      read_element(4'd1, 4'd1);
      configure(MODE_UNUSED, 5'd2, 5'd2, 5'd2, 5'd2);
      read_element(4'd0, 4'd0);
   endtask

   // stall the response side long enough that the core backs up into the request side
   task automatic test_output_backpressure();
      configure(mamt_pkg::MODE_MUL, 5'd16, 5'd16, 5'd16, 5'd16);
      hold_requests++;
      for (int i = 0; i < 12; i++)
         read_element(4'($urandom_range(1)), 4'($urandom_range(3)));
   endtask

   task automatic test_random_traffic(input int target);
      int start_count;
      int burst;
      int choice;
      int shape_r;
      int shape_c;
      logic [1:0] m;
      logic [4:0] ra, ca, rb, cb;
      start_count = sent_items;
      while (sent_items - start_count < target) begin
         m  = 2'($urandom_range(2));
         ra = pick_dim();
         ca = pick_dim();
         case (m)
            mamt_pkg::MODE_ADD: begin rb = ra; cb = ca; end
            mamt_pkg::MODE_MUL: begin rb = ca; cb = pick_dim(); end
            default: begin rb = pick_dim(); cb = pick_dim(); end
         endcase
         choice = $urandom_range(99);
         if (choice < 15) begin
            m  = 2'($urandom_range(3));
            ra = 5'($urandom_range(31));
            ca = 5'($urandom_range(31));
            rb = 5'($urandom_range(31));
            cb = 5'($urandom_range(31));
         end else if (choice < 25) begin
            rb = pick_dim();
         end
         configure(m, ra, ca, rb, cb);
         case (cfg_mode)
            mamt_pkg::MODE_ADD: begin shape_r = cfg_rows_a; shape_c = cfg_cols_a; end
            mamt_pkg::MODE_MUL: begin shape_r = cfg_rows_a; shape_c = cfg_cols_b; end
            mamt_pkg::MODE_TRANSPOSE: begin shape_r = cfg_cols_a; shape_c = cfg_rows_a; end
            default: begin shape_r = MAX_DIM; shape_c = MAX_DIM; end
         endcase
         burst = $urandom_range(15, 50);
         repeat (burst) begin
            choice = $urandom_range(99);
            if (choice < 30)
               send_transaction(mamt_pkg::OP_WRITE_A, pick_index(cfg_rows_a),
                                pick_index(cfg_cols_a), random_element());
            else if (choice < 50)
               send_transaction(mamt_pkg::OP_WRITE_B, pick_index(cfg_rows_b),
                                pick_index(cfg_cols_b), random_element());
            else if (choice < 90)
               read_element(pick_index(shape_r + 1), pick_index(shape_c + 1));
            else if (choice < 95)
               send_transaction(OP_UNUSED, 4'($urandom()), 4'($urandom()), 16'($urandom()));
            else
               send_transaction(($urandom_range(1) != 0) ? mamt_pkg::OP_WRITE_B
                                                          : mamt_pkg::OP_WRITE_A,
                                4'($urandom()), 4'($urandom()), 16'($urandom()));
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken <= holds_taken + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      element_result_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_elements.size() == 0) begin
            report_mismatch($sformatf("unexpected response value=%h status=%0d",
                                      rsp_tdata, rsp_tuser));
         end else begin
            expected = expected_elements.pop_front();
            if (rsp_tdata !== expected.value)
               report_mismatch($sformatf("result_value %h, want %h", rsp_tdata, expected.value));
            if (rsp_tuser !== expected.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, expected.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_add_extremes();
      test_multiply_shapes();
      test_transpose();
      test_dimension_errors();
      test_output_backpressure();
      test_random_traffic(80);
      req_idle_pct = 57;
      rsp_idle_pct = 7;
      test_random_traffic(80);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(80);
      quiesce();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/mamt_pkg.sv
rtl/mamt_ram.sv
rtl/mamt_mac.sv
rtl/matrix_add_multiply_transpose_core.sv
rtl/mamt_checker.sv
bench/tb_matrix_add_multiply_transpose_core.sv
